/* src/rff_pkg.sv */
package rff_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
  localparam logic [1:0] REG_HDR_SECOND = 2'd1;
  localparam logic [1:0] REG_HDR_THIRD  = 2'd2;

  localparam logic [BYTE_W-1:0] HDR_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_SECOND_RST = 8'haa;
  localparam logic [BYTE_W-1:0] HDR_THIRD_RST  = 8'hf0;

  // Fixed frame positions
  localparam int unsigned POS_HDR0 = 0;
  localparam int unsigned POS_HDR1 = 1;
  localparam int unsigned POS_HDR2 = 2;
  localparam int unsigned POS_SEQ  = 3;
  localparam int unsigned POS_PL0  = 4;
  localparam int unsigned POS_PL1  = 5;
  localparam int unsigned POS_PL2  = 6;
  localparam int unsigned POS_CHK  = 7;
  localparam int unsigned POS_TAIL = 10;

  typedef enum logic [1:0] {
    VERD_OK       = 2'd0,
    VERD_BAD_HDR  = 2'd1,
    VERD_REPEAT   = 2'd2,
    VERD_BAD_CSUM = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] third;
  } hdr_t;

  typedef struct packed {
    logic              accepted;
    verdict_t          verdict;
    logic [BYTE_W-1:0] payload_first;
    logic [BYTE_W-1:0] payload_second;
    logic [BYTE_W-1:0] payload_third;
    logic [BYTE_W-1:0] payload_check;
    logic [BYTE_W-1:0] accept_count;
  } res_t;

endpackage

/* src/rff_cfg.sv */
module rff_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rff_pkg::ADDR_W-1:0] paddr,
  input  logic [rff_pkg::DATA_W-1:0] pwdata,
  output logic [rff_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output rff_pkg::hdr_t              hdr
);
  import rff_pkg::*;

  hdr_t       hdr_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign hdr     = hdr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r.first  <= HDR_FIRST_RST;
      hdr_r.second <= HDR_SECOND_RST;
      hdr_r.third  <= HDR_THIRD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HDR_FIRST:  hdr_r.first  <= pwdata[BYTE_W-1:0];
        REG_HDR_SECOND: hdr_r.second <= pwdata[BYTE_W-1:0];
        REG_HDR_THIRD:  hdr_r.third  <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HDR_FIRST:  prdata = {{(DATA_W-BYTE_W){1'b0}}, hdr_r.first};
      REG_HDR_SECOND: prdata = {{(DATA_W-BYTE_W){1'b0}}, hdr_r.second};
      REG_HDR_THIRD:  prdata = {{(DATA_W-BYTE_W){1'b0}}, hdr_r.third};
      default:        prdata = '0;
    endcase
  end

endmodule

/* src/rff_judge.sv */
module rff_judge #(
  parameter int unsigned MAX_FRAME = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_en,
  input  logic [rff_pkg::BYTE_W-1:0] rx_byte,
  input  logic                       frame_start,
  input  rff_pkg::hdr_t              hdr,
  output logic                       res_valid,
  output rff_pkg::res_t              res
);
  import rff_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_FRAME + 1);

  logic [BYTE_W-1:0] store_r   [MAX_FRAME];
  logic [BYTE_W-1:0] store_nxt [MAX_FRAME];
  logic [BYTE_W-1:0] vw        [MAX_FRAME];
  logic [IDX_W-1:0]  idx_r, idx_nxt, idx_inc;
  logic [IDX_W-1:0]  len_r, len_nxt, len_cap;
  logic              coll_r, coll_nxt;
  logic [BYTE_W-1:0] prev_seq_r, prev_seq_nxt;
  logic [BYTE_W-1:0] prev_tail_r, prev_tail_nxt;
  logic              seen_r, seen_nxt;
  logic [4*BYTE_W-1:0] held_r, held_nxt;
  logic [BYTE_W-1:0] total_r, total_nxt;
  logic              judge;
  logic              clear;
  logic              hdr_ok, repeat_hit, csum_ok;
  logic [BYTE_W+1:0] csum;
  verdict_t          verd;

  assign len_cap = (rx_byte > BYTE_W'(MAX_FRAME)) ? IDX_W'(MAX_FRAME) : rx_byte[IDX_W-1:0];
  assign idx_inc = idx_r + IDX_W'(1);

  always_comb begin
    judge = 1'b0;
    clear = 1'b0;
    idx_nxt  = idx_r;
    len_nxt  = len_r;
    coll_nxt = coll_r;
    for (int i = 0; i < MAX_FRAME; i++) begin
      store_nxt[i] = store_r[i];
      vw[i]        = store_r[i];
    end
    if (item_en) begin
      if (frame_start) begin
        // drop any partial frame and start afresh
        for (int i = 0; i < MAX_FRAME; i++) vw[i] = '0;
        clear    = 1'b1;
        idx_nxt  = '0;
        len_nxt  = len_cap;
        coll_nxt = (len_cap != '0);
        judge    = (len_cap == '0);
      end else if (coll_r) begin
        for (int i = 0; i < MAX_FRAME; i++) begin
          if (idx_r == IDX_W'(i)) vw[i] = rx_byte;
        end
        idx_nxt = idx_inc;
        if (idx_inc >= len_r) begin
          judge    = 1'b1;
          clear    = 1'b1;
          coll_nxt = 1'b0;
          idx_nxt  = '0;
          len_nxt  = '0;
        end
      end
    end
    for (int i = 0; i < MAX_FRAME; i++) begin
      store_nxt[i] = clear ? '0 : vw[i];
    end
  end

  assign hdr_ok = (vw[POS_HDR0] == hdr.first) && (vw[POS_HDR1] == hdr.second) &&
                  (vw[POS_HDR2] == hdr.third);
  assign repeat_hit = (vw[POS_SEQ] == prev_seq_r) || (vw[POS_TAIL] == prev_tail_r);
  assign csum = {2'b00, vw[POS_PL0]} + {2'b00, vw[POS_PL1]} + {2'b00, vw[POS_PL2]};
  assign csum_ok = ({2'b00, vw[POS_CHK]} == csum);

  always_comb begin
    verd          = VERD_OK;
    prev_seq_nxt  = prev_seq_r;
    prev_tail_nxt = prev_tail_r;
    seen_nxt      = seen_r;
    held_nxt      = held_r;
    total_nxt     = total_r;
    if (!hdr_ok) begin
      verd = VERD_BAD_HDR;
    end else if (repeat_hit) begin
      verd = VERD_REPEAT;
    end else begin
      // pair advances even when the checksum then fails
      prev_seq_nxt  = vw[POS_SEQ];
      prev_tail_nxt = vw[POS_TAIL];
      if (!csum_ok) begin
        verd = VERD_BAD_CSUM;
      end else begin
        if (seen_r) total_nxt = total_r + BYTE_W'(1);
        seen_nxt = 1'b1;
        held_nxt = {vw[POS_CHK], vw[POS_PL2], vw[POS_PL1], vw[POS_PL0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_FRAME; i++) store_r[i] <= '0;
      idx_r       <= '0;
      len_r       <= '0;
      coll_r      <= 1'b0;
      prev_seq_r  <= '0;
      prev_tail_r <= '0;
      seen_r      <= 1'b0;
      held_r      <= '0;
      total_r     <= '0;
    end else begin
      for (int i = 0; i < MAX_FRAME; i++) store_r[i] <= store_nxt[i];
      idx_r  <= idx_nxt;
      len_r  <= len_nxt;
      coll_r <= coll_nxt;
      if (judge) begin
        prev_seq_r  <= prev_seq_nxt;
        prev_tail_r <= prev_tail_nxt;
        seen_r      <= seen_nxt;
        held_r      <= held_nxt;
        total_r     <= total_nxt;
      end
    end
  end

  assign res_valid          = judge;
  assign res.accepted       = (verd == VERD_OK);
  assign res.verdict        = verd;
  assign res.payload_first  = held_nxt[BYTE_W-1:0];
  assign res.payload_second = held_nxt[2*BYTE_W-1:BYTE_W];
  assign res.payload_third  = held_nxt[3*BYTE_W-1:2*BYTE_W];
  assign res.payload_check  = held_nxt[4*BYTE_W-1:3*BYTE_W];
  assign res.accept_count   = total_nxt;

endmodule

/* src/rff_skid.sv */
module rff_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rff_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output rff_pkg::res_t out_data
);
  import rff_pkg::*;

  res_t out_r, skid_r;
  logic out_v_r, skid_v_r;
  logic pop;

  assign pop       = out_v_r & ~out_stall;
  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      out_r <= skid_v_r ? skid_r : push_data;
    end else if (push) begin
      // hold the waiting item, park the new one
      skid_r <= push_data;
    end
  end

endmodule

/* src/rf_frame_filter_core.sv */
// Channel | Handshake                  | Payload
// in      | in_valid / in_stall        | in_rx_byte, in_frame_start
// out     | out_valid / out_stall      | out_accepted, out_verdict, out_payload_*,
//         |                            | out_accept_count
// cfg     | psel penable pwrite pready | paddr, pwdata, prdata
//
// One byte is taken every cycle while in_stall is low; a finished frame's result is
// formed from its last byte by the single combinational judge stage between the
// frame store and the result register. A two-entry output buffer absorbs a stalled
// result; in_stall rises only when both entries are full.
// Reset (rst_n low, synchronous) clears the frame store, repeat pair, payload
// and counter, and loads the header registers with their defaults.
module rf_frame_filter_core #(
  parameter int unsigned MAX_FRAME = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rff_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                       in_frame_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_accepted,
  output logic [1:0]                 out_verdict,
  output logic [rff_pkg::BYTE_W-1:0] out_payload_first,
  output logic [rff_pkg::BYTE_W-1:0] out_payload_second,
  output logic [rff_pkg::BYTE_W-1:0] out_payload_third,
  output logic [rff_pkg::BYTE_W-1:0] out_payload_check,
  output logic [rff_pkg::BYTE_W-1:0] out_accept_count,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rff_pkg::ADDR_W-1:0] paddr,
  input  logic [rff_pkg::DATA_W-1:0] pwdata,
  output logic [rff_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import rff_pkg::*;

  hdr_t hdr;
  res_t res, out_res;
  logic res_valid;
  logic full;
  logic item_en;

  assign in_stall = full;
  assign item_en  = in_valid & ~full;

  rff_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .hdr     (hdr)
  );

  rff_judge #(
    .MAX_FRAME (MAX_FRAME)
  ) u_judge (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_en     (item_en),
    .rx_byte     (in_rx_byte),
    .frame_start (in_frame_start),
    .hdr         (hdr),
    .res_valid   (res_valid),
    .res         (res)
  );

  rff_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_accepted       = out_res.accepted;
  assign out_verdict        = out_res.verdict;
  assign out_payload_first  = out_res.payload_first;
  assign out_payload_second = out_res.payload_second;
  assign out_payload_third  = out_res.payload_third;
  assign out_payload_check  = out_res.payload_check;
  assign out_accept_count   = out_res.accept_count;

endmodule
